// ===== hdl/spq_pkg.sv =====
// Shared types, codes and defaults for the stable priority queue.
package spq_pkg;

   localparam int DEFAULT_CAPACITY = 16;

   localparam int KIND_W     = 2;
   localparam int ID_W       = 16;
   localparam int PAYLOAD_W  = 16;
   localparam int PRIORITY_W = 8;
   localparam int STATUS_W   = 2;
   localparam int WORD_W     = 17;
   localparam int OCC_W      = 5;

   localparam logic [KIND_W-1:0] KIND_ENQUEUE = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DEQUEUE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_REMOVE  = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   localparam logic signed [WORD_W-1:0] WORD_NONE = '1;

   typedef enum logic [1:0] {
      OP_HOLD,
      OP_INSERT,
      OP_SHIFT,
      OP_REMOVE
   } op_type;

   typedef struct packed {
      logic [ID_W-1:0]       id;
      logic [PAYLOAD_W-1:0]  payload;
      logic [PRIORITY_W-1:0] prio;
   } entry_type;

   // Broadcast to every cell: operation plus the request entry
   typedef struct packed {
      op_type    op;
      entry_type req;
   } cmd_type;

endpackage

// ===== hdl/spq_cell.sv =====
// One slot of the sorted queue: holds an entry and trades it with its neighbors.
module spq_cell (
   input  logic               clock,
   input  spq_pkg::cmd_type   cmd,
   input  logic               occupied,
   input  spq_pkg::entry_type left_entry,
   input  logic               left_keep,
   input  spq_pkg::entry_type right_entry,
   input  logic               found_in,
   output spq_pkg::entry_type entry,
   output logic               keep,
   output logic               found_out
);
   import spq_pkg::*;

   entry_type entry_ff;
   entry_type entry_in;
   logic      match;

   // Entries that outrank or tie the new one stay put, which keeps arrival order
   assign keep      = occupied && (entry_ff.prio >= cmd.req.prio);
   assign match     = occupied && (entry_ff.id == cmd.req.id);
   assign found_out = found_in || match;
   assign entry     = entry_ff;

   always_comb begin
      entry_in = entry_ff;
      case (cmd.op)
         OP_INSERT: begin
            if (!keep) begin
               entry_in = left_keep ? cmd.req : left_entry;
            end
         end
         OP_SHIFT: begin
            entry_in = right_entry;
         end
         OP_REMOVE: begin
            if (found_out) begin
               entry_in = right_entry;
            end
         end
         default: begin
            entry_in = entry_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
   end

endmodule

// ===== hdl/stable_priority_queue_with_remove.sv =====
// Top level of the stable priority queue: cell chain, fill count and result register.
//
// Usage:
//   The req_ channel carries one command per item: enqueue (id, payload,
//   priority), dequeue the head, or remove the first entry with a given id.
//   The rsp_ channel returns exactly one result item per command: status,
//   the dequeued id/payload (-1 when nothing was taken), the head after the
//   command (-1 when empty), the occupancy and an empty flag.
//   Entries live in a row of CAPACITY cells; every cell decides in the same
//   cycle whether to hold, take the new entry, or take a neighbor's entry,
//   so higher priorities sit toward cell 0 and ties keep arrival order.
//   The result is registered and appears in the cycle after the command is taken.
//   Throughput: one command per cycle; the remove search ripples a found
//   flag through the chain, so that path grows with CAPACITY.
//   Stall: while rsp_valid is high and rsp_ready is low, req_ready drops
//   and the queue holds; the result stays unchanged until taken.
//   Reset: synchronous; clears the fill count and the result valid, so the
//   queue comes up empty. Slot contents are not cleared.
module stable_priority_queue_with_remove #(
   parameter int CAPACITY = spq_pkg::DEFAULT_CAPACITY
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [spq_pkg::KIND_W-1:0]         req_kind,
   input  logic [spq_pkg::ID_W-1:0]           req_aircraft_id,
   input  logic [spq_pkg::PAYLOAD_W-1:0]      req_request_payload,
   input  logic [spq_pkg::PRIORITY_W-1:0]     req_priority_req,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [spq_pkg::STATUS_W-1:0]       rsp_status,
   output logic signed [spq_pkg::WORD_W-1:0]  rsp_taken_id,
   output logic signed [spq_pkg::WORD_W-1:0]  rsp_taken_payload,
   output logic signed [spq_pkg::WORD_W-1:0]  rsp_head_id,
   output logic signed [spq_pkg::WORD_W-1:0]  rsp_head_payload,
   output logic [spq_pkg::OCC_W-1:0]          rsp_occupancy,
   output logic                               rsp_empty_flag
);
   import spq_pkg::*;

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic                 accept;
   logic [CNT_W-1:0]     count_ff;
   logic [CNT_W-1:0]     count_in;
   logic                 is_full;
   logic                 no_entries;
   cmd_type              cmd;
   entry_type            req_entry;
   entry_type            cell_entry [CAPACITY];
   logic                 cell_keep  [CAPACITY];
   logic                 cell_found [CAPACITY+1];
   entry_type            head_in;
   logic [STATUS_W-1:0]  status_in;
   logic                 taken_in;

   logic                       rsp_valid_ff;
   logic [STATUS_W-1:0]        status_ff;
   logic signed [WORD_W-1:0]   taken_id_ff;
   logic signed [WORD_W-1:0]   taken_payload_ff;
   logic signed [WORD_W-1:0]   head_id_ff;
   logic signed [WORD_W-1:0]   head_payload_ff;
   logic [OCC_W-1:0]           occupancy_ff;
   logic                       empty_ff;

   // Take a new command whenever the result register is free or draining
   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign accept     = req_valid && req_ready;
   assign is_full    = (count_ff == CNT_W'(CAPACITY));
   assign no_entries = (count_ff == '0);

   assign req_entry.id      = req_aircraft_id;
   assign req_entry.payload = req_request_payload;
   assign req_entry.prio    = req_priority_req;

   // Decode the command into one chain-wide operation
   always_comb begin
      cmd.req   = req_entry;
      cmd.op    = OP_HOLD;
      status_in = STATUS_OK;
      taken_in  = 1'b0;
      if (accept) begin
         case (req_kind)
            KIND_ENQUEUE: begin
               if (is_full) begin
                  status_in = STATUS_FULL;
               end else begin
                  cmd.op = OP_INSERT;
               end
            end
            KIND_DEQUEUE: begin
               if (no_entries) begin
                  status_in = STATUS_EMPTY;
               end else begin
                  cmd.op   = OP_SHIFT;
                  taken_in = 1'b1;
               end
            end
            KIND_REMOVE: begin
               cmd.op = OP_REMOVE;
               if (!cell_found[CAPACITY]) begin
                  status_in = STATUS_NOT_FOUND;
               end
            end
            default: begin
               cmd.op = OP_HOLD;
            end
         endcase
      end
   end

   // Cell chain: cell 0 is the head; the found flag ripples toward the tail
   assign cell_found[0] = 1'b0;

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      spq_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .occupied    (CNT_W'(i) < count_ff),
         .left_entry  ((i == 0) ? req_entry : cell_entry[(i == 0) ? 0 : i-1]),
         .left_keep   ((i == 0) ? 1'b1 : cell_keep[(i == 0) ? 0 : i-1]),
         .right_entry ((i == CAPACITY-1) ? cell_entry[i]
                                         : cell_entry[(i == CAPACITY-1) ? i : i+1]),
         .found_in    (cell_found[i]),
         .entry       (cell_entry[i]),
         .keep        (cell_keep[i]),
         .found_out   (cell_found[i+1])
      );
   end

   // Advance the fill count and work out the head the chain will hold
   always_comb begin
      count_in = count_ff;
      head_in  = cell_entry[0];
      case (cmd.op)
         OP_INSERT: begin
            count_in = count_ff + 1'b1;
            if (!cell_keep[0]) begin
               head_in = req_entry;
            end
         end
         OP_SHIFT: begin
            count_in = count_ff - 1'b1;
            head_in  = cell_entry[1];
         end
         OP_REMOVE: begin
            if (cell_found[CAPACITY]) begin
               count_in = count_ff - 1'b1;
            end
            if (cell_found[1]) begin
               head_in = cell_entry[1];
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Result register: load on accept, hold while the receiver stalls
   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff        <= status_in;
         taken_id_ff      <= taken_in ? WORD_W'(cell_entry[0].id) : WORD_NONE;
         taken_payload_ff <= taken_in ? WORD_W'(cell_entry[0].payload) : WORD_NONE;
         head_id_ff       <= (count_in == '0) ? WORD_NONE : WORD_W'(head_in.id);
         head_payload_ff  <= (count_in == '0) ? WORD_NONE : WORD_W'(head_in.payload);
         occupancy_ff     <= OCC_W'(count_in);
         empty_ff         <= (count_in == '0);
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = status_ff;
   assign rsp_taken_id      = taken_id_ff;
   assign rsp_taken_payload = taken_payload_ff;
   assign rsp_head_id       = head_id_ff;
   assign rsp_head_payload  = head_payload_ff;
   assign rsp_occupancy     = occupancy_ff;
   assign rsp_empty_flag    = empty_ff;

endmodule
